// File: design/ctt_pkg.sv
package ctt_pkg;

   // scanner modes
   typedef enum logic [3:0] {
      M_NORMAL,
      M_IDENT,
      M_STRING,
      M_STRING_BS,
      M_SLASH,
      M_LINE,
      M_BLOCK,
      M_BLOCK_SLASH,
      M_BLOCK_STAR
   } mode_type;

   // token kinds
   localparam logic [2:0] K_IDENT   = 3'd0;
   localparam logic [2:0] K_STRING  = 3'd1;
   localparam logic [2:0] K_LPAREN  = 3'd2;
   localparam logic [2:0] K_RPAREN  = 3'd3;
   localparam logic [2:0] K_COMMA   = 3'd4;
   localparam logic [2:0] K_SEMI    = 3'd5;
   localparam logic [2:0] K_UNKNOWN = 3'd6;
   localparam logic [2:0] K_END     = 3'd7;

   // record kinds
   localparam logic REC_VALUE = 1'b0;
   localparam logic REC_END   = 1'b1;

   // characters
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_SEMI      = 8'h3B;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDERLINE = 8'h5F;
   localparam logic [1:0] UTF8_CONT    = 2'b10;

endpackage

// File: design/ctt_req_if.sv
interface ctt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// File: design/ctt_rsp_if.sv
interface ctt_rsp_if #(
   parameter int POSITION_BITS = 24,
   parameter int LENGTH_BITS = 16
);
   logic                     valid;
   logic                     ready;
   logic                     record_kind;
   logic [2:0]               token_kind;
   logic [7:0]               value_byte;
   logic [POSITION_BITS-1:0] first_line;
   logic [POSITION_BITS-1:0] first_column;
   logic [LENGTH_BITS-1:0]   value_length;
   logic                     last_in_run;

   modport source (
      output valid, output record_kind, output token_kind, output value_byte,
      output first_line, output first_column, output value_length, output last_in_run,
      input ready
   );
   modport sink (
      input valid, input record_kind, input token_kind, input value_byte,
      input first_line, input first_column, input value_length, input last_in_run,
      output ready
   );
endinterface

// File: design/config_text_tokenizer.sv
// Channel | Dir | Payload                                              | Accept
// req     | in  | text_byte, end_of_text                               | valid & ready
// rsp     | out | record_kind, token_kind, value_byte, first_line,     | valid & ready
//         |     | first_column, value_length, last_in_run              |
//
// An input word is scanned in the cycle it is accepted; its zero to four result
// words land in a four-entry output buffer and leave one per cycle while
// rsp.ready is high. A word that yields two or more results holds req.ready low
// while the buffer drains down to its last entry.
// A new word is taken while the last buffered result is being taken.
// Synchronous reset clears the scanner state and empties the buffer.
module config_text_tokenizer #(
   parameter int POSITION_BITS = 24,
   parameter int LENGTH_BITS = 16,
   parameter int DEPTH_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   ctt_req_if.sink       req,
   ctt_rsp_if.source     rsp
);
   import ctt_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
   localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);
   localparam logic [DEPTH_BITS-1:0]    DEP_ONE = DEPTH_BITS'(1);

   typedef struct packed {
      logic                     rk;
      logic [2:0]               kind;
      logic [7:0]               value;
      logic [POSITION_BITS-1:0] line;
      logic [POSITION_BITS-1:0] column;
      logic [LENGTH_BITS-1:0]   length;
      logic                     last;
   } rec_type;

   typedef struct packed {
      mode_type                 mode;
      logic [DEPTH_BITS-1:0]    depth;
      logic [POSITION_BITS-1:0] tl;
      logic [POSITION_BITS-1:0] tc;
      logic [LENGTH_BITS-1:0]   tlen;
      rec_type [3:0]            rec;
      logic [2:0]               n;
   } scan_type;

   mode_type                 mode_ff, mode_in;
   logic [DEPTH_BITS-1:0]    depth_ff, depth_in;
   logic [POSITION_BITS-1:0] tl_ff, tl_in;
   logic [POSITION_BITS-1:0] tc_ff, tc_in;
   logic [LENGTH_BITS-1:0]   tlen_ff, tlen_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] col_ff, col_in;
   rec_type [3:0]            q_ff, q_in;
   logic [2:0]               cnt_ff, cnt_in;

   logic accept;
   logic pop;

   function automatic logic [POSITION_BITS-1:0] sat_pos(logic [POSITION_BITS-1:0] v);
      return (v == '1) ? v : v + POS_ONE;
   endfunction

   function automatic scan_type f_put(scan_type s, logic rk, logic [2:0] kind,
                                      logic [7:0] v, logic [LENGTH_BITS-1:0] len);
      rec_type r;
      r.rk     = rk;
      r.kind   = kind;
      r.value  = v;
      r.line   = s.tl;
      r.column = s.tc;
      r.length = len;
      r.last   = 1'b0;
      if (s.n != 3'd4) begin
         s.rec[s.n[1:0]] = r;
         s.n = s.n + 3'd1;
      end
      return s;
   endfunction

   function automatic scan_type f_value(scan_type s, logic [2:0] kind, logic [7:0] b);
      if (s.tlen != '1) begin
         s.tlen = s.tlen + LEN_ONE;
      end
      return f_put(s, REC_VALUE, kind, b, '0);
   endfunction

   function automatic scan_type f_end(scan_type s, logic [2:0] kind);
      return f_put(s, REC_END, kind, 8'h00, s.tlen);
   endfunction

   function automatic scan_type f_start(scan_type s, logic [POSITION_BITS-1:0] ln,
                                        logic [POSITION_BITS-1:0] col);
      s.tl   = ln;
      s.tc   = col;
      s.tlen = '0;
      return s;
   endfunction

   function automatic scan_type f_normal(scan_type s, logic [7:0] b,
                                         logic [POSITION_BITS-1:0] ln,
                                         logic [POSITION_BITS-1:0] col);
      logic [2:0] kind;
      s.mode = M_NORMAL;
      if (b inside {8'h20, [8'h09:8'h0D]}) begin
         return s;
      end
      s = f_start(s, ln, col);
      if (b == CH_SLASH) begin
         s.mode = M_SLASH;
      end else if (b inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDERLINE}) begin
         s.mode = M_IDENT;
         s = f_value(s, K_IDENT, b);
      end else if (b == CH_QUOTE) begin
         s.mode = M_STRING;
      end else begin
         case (b)
            CH_LPAREN: kind = K_LPAREN;
            CH_RPAREN: kind = K_RPAREN;
            CH_COMMA:  kind = K_COMMA;
            CH_SEMI:   kind = K_SEMI;
            default:   kind = K_UNKNOWN;
         endcase
         s = f_value(s, kind, b);
         s = f_end(s, kind);
      end
      return s;
   endfunction

   function automatic scan_type f_string(scan_type s, logic [7:0] b,
                                         logic [POSITION_BITS-1:0] ln,
                                         logic [POSITION_BITS-1:0] col);
      s.mode = M_STRING;
      if (b == CH_QUOTE) begin
         s = f_end(s, K_STRING);
         s.mode = M_NORMAL;
      end else if (b == CH_NUL) begin
         s = f_end(s, K_UNKNOWN);
         s = f_normal(s, b, ln, col);
      end else if (b == CH_BACKSLASH) begin
         s.mode = M_STRING_BS;
      end else begin
         s = f_value(s, K_STRING, b);
      end
      return s;
   endfunction

   function automatic mode_type f_block(logic [7:0] b);
      if (b == CH_SLASH) begin
         return M_BLOCK_SLASH;
      end else if (b == CH_STAR) begin
         return M_BLOCK_STAR;
      end
      return M_BLOCK;
   endfunction

   assign accept = req.valid && req.ready;
   assign pop    = rsp.valid && rsp.ready;

   // take a new word once the buffer is empty or its last entry leaves now
   assign req.ready = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp.ready);

   // scanner
   always_comb begin
      scan_type   s;
      logic [7:0] b;
      logic [1:0] idx;
      b         = req.text_byte;
      s.mode    = mode_ff;
      s.depth   = depth_ff;
      s.tl      = tl_ff;
      s.tc      = tc_ff;
      s.tlen    = tlen_ff;
      s.rec     = '0;
      s.n       = 3'd0;
      line_in   = line_ff;
      col_in    = col_ff;
      if (req.end_of_text) begin
         case (mode_ff)
            M_IDENT: s = f_end(s, K_IDENT);
            M_STRING_BS: begin
               s = f_value(s, K_STRING, CH_BACKSLASH);
               s = f_end(s, K_UNKNOWN);
            end
            M_STRING: s = f_end(s, K_UNKNOWN);
            M_SLASH: begin
               s = f_value(s, K_UNKNOWN, CH_SLASH);
               s = f_end(s, K_UNKNOWN);
            end
            default: ;
         endcase
         // end token sits at the current position
         s.tl = line_ff;
         s.tc = col_ff;
         s    = f_put(s, REC_END, K_END, 8'h00, '0);
         s.mode  = M_NORMAL;
         s.depth = '0;
         s.tl    = POS_ONE;
         s.tc    = POS_ONE;
         s.tlen  = '0;
         line_in = POS_ONE;
         col_in  = POS_ONE;
      end else begin
         case (mode_ff)
            M_IDENT: begin
               if (b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], CH_UNDERLINE}) begin
                  s = f_value(s, K_IDENT, b);
               end else begin
                  s = f_end(s, K_IDENT);
                  s = f_normal(s, b, line_ff, col_ff);
               end
            end
            M_STRING: s = f_string(s, b, line_ff, col_ff);
            M_STRING_BS: begin
               if (b == CH_QUOTE) begin
                  s = f_value(s, K_STRING, CH_QUOTE);
                  s.mode = M_STRING;
               end else begin
                  s = f_value(s, K_STRING, CH_BACKSLASH);
                  s = f_string(s, b, line_ff, col_ff);
               end
            end
            M_SLASH: begin
               if (b == CH_SLASH) begin
                  s.mode = M_LINE;
               end else if (b == CH_STAR) begin
                  s.mode  = M_BLOCK;
                  s.depth = DEP_ONE;
               end else begin
                  // lone slash
                  s = f_value(s, K_UNKNOWN, CH_SLASH);
                  s = f_end(s, K_UNKNOWN);
                  s = f_normal(s, b, line_ff, col_ff);
               end
            end
            M_LINE: begin
               if ((b == CH_LF) || (b == CH_NUL)) begin
                  s = f_normal(s, b, line_ff, col_ff);
               end
            end
            M_BLOCK: s.mode = f_block(b);
            M_BLOCK_SLASH: begin
               if (b == CH_STAR) begin
                  if (s.depth != '1) begin
                     s.depth = s.depth + DEP_ONE;
                  end
                  s.mode = M_BLOCK;
               end else begin
                  s.mode = f_block(b);
               end
            end
            M_BLOCK_STAR: begin
               if (b == CH_SLASH) begin
                  if (s.depth <= DEP_ONE) begin
                     s.depth = '0;
                     s.mode  = M_NORMAL;
                  end else begin
                     s.depth = s.depth - DEP_ONE;
                     s.mode  = M_BLOCK;
                  end
               end else begin
                  s.mode = f_block(b);
               end
            end
            default: s = f_normal(s, b, line_ff, col_ff);
         endcase
         if (b == CH_LF) begin
            line_in = sat_pos(line_ff);
            col_in  = POS_ONE;
         end else if (b[7:6] != UTF8_CONT) begin
            col_in = sat_pos(col_ff);
         end
      end
      idx = 2'(s.n - 3'd1);
      if (s.n != 3'd0) begin
         s.rec[idx].last = 1'b1;
      end
      mode_in  = s.mode;
      depth_in = s.depth;
      tl_in    = s.tl;
      tc_in    = s.tc;
      tlen_in  = s.tlen;
      // load a fresh batch, else shift the buffer down on a pop
      if (accept) begin
         q_in   = s.rec;
         cnt_in = s.n;
      end else if (pop) begin
         q_in[0] = q_ff[1];
         q_in[1] = q_ff[2];
         q_in[2] = q_ff[3];
         q_in[3] = q_ff[3];
         cnt_in  = cnt_ff - 3'd1;
      end else begin
         q_in   = q_ff;
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_NORMAL;
         depth_ff <= '0;
         tl_ff    <= POS_ONE;
         tc_ff    <= POS_ONE;
         tlen_ff  <= '0;
         line_ff  <= POS_ONE;
         col_ff   <= POS_ONE;
         cnt_ff   <= 3'd0;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            depth_ff <= depth_in;
            tl_ff    <= tl_in;
            tc_ff    <= tc_in;
            tlen_ff  <= tlen_in;
            line_ff  <= line_in;
            col_ff   <= col_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign rsp.valid        = (cnt_ff != 3'd0);
   assign rsp.record_kind  = q_ff[0].rk;
   assign rsp.token_kind   = q_ff[0].kind;
   assign rsp.value_byte   = q_ff[0].value;
   assign rsp.first_line   = q_ff[0].line;
   assign rsp.first_column = q_ff[0].column;
   assign rsp.value_length = q_ff[0].length;
   assign rsp.last_in_run  = q_ff[0].last;

endmodule

// File: design/ctt_checker.sv
module ctt_checker #(
   parameter int POSITION_BITS = 24
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_record_kind,
   input logic [2:0]               rsp_token_kind,
   input logic [7:0]               rsp_value_byte,
   input logic [POSITION_BITS-1:0] rsp_first_line,
   input logic [POSITION_BITS-1:0] rsp_first_column,
   input logic                     rsp_last_in_run
);
   import ctt_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_byte)
         && $stable(rsp_token_kind) && $stable(rsp_record_kind))
      else $error("result word changed while stalled");

   // no new word while a result is stuck in the buffer
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("input taken while a result was stalled");

   // end of text closes its run
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record_kind == REC_END) && (rsp_token_kind == K_END)
         |-> rsp_last_in_run)
      else $error("end token not last in run");

   // positions count from one
   a_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_first_line != '0) && (rsp_first_column != '0))
      else $error("zero start position");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind config_text_tokenizer ctt_checker #(
   .POSITION_BITS(POSITION_BITS)
) u_ctt_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_record_kind(rsp.record_kind),
   .rsp_token_kind(rsp.token_kind),
   .rsp_value_byte(rsp.value_byte),
   .rsp_first_line(rsp.first_line),
   .rsp_first_column(rsp.first_column),
   .rsp_last_in_run(rsp.last_in_run)
);
